FILE: design/mi3_pkg.sv
// Package for the 3x3 matrix inverse core: widths, payload structs and
// cofactor index tables. Depends on nothing; used by every design file.
`timescale 1ns / 1ps
package mi3_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int N_ELEM    = 9;
  localparam int COF_W     = 64;
  localparam int DET_W     = 97;
  localparam int DEN_W     = DET_W + 1;
  localparam int Q_W       = 34;
  localparam int DIV_W     = DEN_W + Q_W;
  localparam int NUM_SHIFT = 2 * FRAC_BITS + 1;
  localparam int LATENCY   = 6 + Q_W;

  localparam logic [Q_W-1:0] SAT_POS_Q = Q_W'(32'h7FFF_FFFF);
  localparam logic [Q_W-1:0] SAT_NEG_Q = Q_W'(32'h8000_0000);
  localparam logic [ELEM_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] SAT_NEG = 32'h8000_0000;

  // Adjugate entry r*3+c is m[a]*m[b] - m[c]*m[d], elements indexed r*3+c.
  localparam int COF_IDX [N_ELEM][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef struct packed {
    logic signed [ELEM_W-1:0] in_r0c0;
    logic signed [ELEM_W-1:0] in_r0c1;
    logic signed [ELEM_W-1:0] in_r0c2;
    logic signed [ELEM_W-1:0] in_r1c0;
    logic signed [ELEM_W-1:0] in_r1c1;
    logic signed [ELEM_W-1:0] in_r1c2;
    logic signed [ELEM_W-1:0] in_r2c0;
    logic signed [ELEM_W-1:0] in_r2c1;
    logic signed [ELEM_W-1:0] in_r2c2;
  } mi3_in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] out_r0c0;
    logic signed [ELEM_W-1:0] out_r0c1;
    logic signed [ELEM_W-1:0] out_r0c2;
    logic signed [ELEM_W-1:0] out_r1c0;
    logic signed [ELEM_W-1:0] out_r1c1;
    logic signed [ELEM_W-1:0] out_r1c2;
    logic signed [ELEM_W-1:0] out_r2c0;
    logic signed [ELEM_W-1:0] out_r2c1;
    logic signed [ELEM_W-1:0] out_r2c2;
    logic                     singular;
  } mi3_out_t;

  typedef struct packed {
    logic                             vld;
    logic [2:0][ELEM_W-1:0]           row0;
    logic [N_ELEM-1:0][COF_W-1:0]     cof;
  } mi3_cof_t;

  typedef struct packed {
    logic                             vld;
    logic                             sing;
    logic [DEN_W-1:0]                 den;
    logic [N_ELEM-1:0]                neg;
    logic [N_ELEM-1:0][DIV_W-1:0]     rem;
    logic [N_ELEM-1:0][Q_W-1:0]       quo;
  } mi3_div_t;

endpackage

FILE: design/mi3_cofactor.sv
// Two pipeline stages: the eighteen element products, then the nine cofactors.
// Depends on mi3_pkg.
`timescale 1ns / 1ps
module mi3_cofactor
  import mi3_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_vld,
  input  mi3_in_t  in_data,
  output mi3_cof_t cof_o
);

  logic [N_ELEM-1:0][ELEM_W-1:0] m;
  logic signed [COF_W-1:0] p_nxt [N_ELEM];
  logic signed [COF_W-1:0] q_nxt [N_ELEM];
  logic signed [COF_W-1:0] p_r [N_ELEM];
  logic signed [COF_W-1:0] q_r [N_ELEM];
  logic [2:0][ELEM_W-1:0] row0_r;
  logic vld_r;
  mi3_cof_t cof_nxt;
  mi3_cof_t cof_r;

  assign m = in_data;

  always_comb begin
    for (int e = 0; e < N_ELEM; e++) begin
      p_nxt[e] = $signed(m[N_ELEM-1-COF_IDX[e][0]]) * $signed(m[N_ELEM-1-COF_IDX[e][1]]);
      q_nxt[e] = $signed(m[N_ELEM-1-COF_IDX[e][2]]) * $signed(m[N_ELEM-1-COF_IDX[e][3]]);
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    q_r <= q_nxt;
    row0_r <= {m[N_ELEM-3], m[N_ELEM-2], m[N_ELEM-1]};
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_comb begin
    cof_nxt.vld = vld_r;
    cof_nxt.row0 = row0_r;
    for (int e = 0; e < N_ELEM; e++) begin
      cof_nxt.cof[e] = p_r[e] - q_r[e];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cof_r <= '0;
    end else begin
      cof_r <= cof_nxt;
    end
  end

  assign cof_o = cof_r;

endmodule

FILE: design/mi3_det.sv
// Three pipeline stages: determinant partial products, their sum, and the
// dividend and divisor set-up for the divider. Depends on mi3_pkg.
`timescale 1ns / 1ps
module mi3_det
  import mi3_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mi3_cof_t cof_i,
  output mi3_div_t div_o
);

  logic signed [ELEM_W+32:0] lo_nxt [3];
  logic signed [COF_W-1:0]   hi_nxt [3];
  logic signed [ELEM_W+32:0] lo_r [3];
  logic signed [COF_W-1:0]   hi_r [3];
  logic [N_ELEM-1:0][COF_W-1:0] cof_a_r;
  logic [N_ELEM-1:0][COF_W-1:0] cof_b_r;
  logic vld_a_r;
  logic vld_b_r;
  logic signed [DET_W-1:0] det_nxt;
  logic signed [DET_W-1:0] det_r;
  logic [DET_W-1:0] dmag;
  logic [COF_W-1:0] cmag;
  logic dneg;
  mi3_div_t div_nxt;
  mi3_div_t div_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lo_nxt[c] = $signed(cof_i.row0[c]) * $signed({1'b0, cof_i.cof[c*3][31:0]});
      hi_nxt[c] = $signed(cof_i.row0[c]) * $signed(cof_i.cof[c*3][COF_W-1:32]);
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    cof_a_r <= cof_i.cof;
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else begin
      vld_a_r <= cof_i.vld;
    end
  end

  always_comb begin
    det_nxt = '0;
    for (int c = 0; c < 3; c++) begin
      det_nxt = det_nxt + (DET_W'(hi_r[c]) <<< 32) + DET_W'(lo_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    det_r <= det_nxt;
    cof_b_r <= cof_a_r;
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else begin
      vld_b_r <= vld_a_r;
    end
  end

  always_comb begin
    dneg = det_r[DET_W-1];
    dmag = dneg ? DET_W'(-det_r) : DET_W'(det_r);
    div_nxt.vld = vld_b_r;
    div_nxt.sing = (det_r == '0);
    div_nxt.den = {dmag, 1'b0};
    cmag = '0;
    for (int e = 0; e < N_ELEM; e++) begin
      cmag = cof_b_r[e][COF_W-1] ? (~cof_b_r[e] + 1'b1) : cof_b_r[e];
      div_nxt.neg[e] = cof_b_r[e][COF_W-1] ^ dneg;
      div_nxt.rem[e] = (DIV_W'(cmag) << NUM_SHIFT) + DIV_W'(dmag);
      div_nxt.quo[e] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= '0;
    end else begin
      div_r <= div_nxt;
    end
  end

  assign div_o = div_r;

endmodule

FILE: design/mi3_divider.sv
// Pipelined restoring divider, one quotient bit per stage for all nine lanes,
// followed by sign, saturation and the singular override. Depends on mi3_pkg.
`timescale 1ns / 1ps
module mi3_divider
  import mi3_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mi3_div_t div_i,
  output logic     out_valid,
  output mi3_out_t out_data
);

  mi3_div_t st [Q_W+1];

  assign st[0] = div_i;

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int K = Q_W - 1 - s;
    mi3_div_t stage_nxt;
    mi3_div_t stage_r;
    logic [DIV_W-1:0] sh;

    always_comb begin
      stage_nxt = st[s];
      sh = DIV_W'(st[s].den) << K;
      for (int e = 0; e < N_ELEM; e++) begin
        if (st[s].rem[e] >= sh) begin
          stage_nxt.rem[e] = st[s].rem[e] - sh;
          stage_nxt.quo[e][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r <= '0;
      end else begin
        stage_r <= stage_nxt;
      end
    end

    assign st[s+1] = stage_r;
  end

  logic [N_ELEM-1:0][ELEM_W-1:0] res;
  logic [Q_W-1:0] q;
  mi3_out_t out_nxt;
  mi3_out_t out_r;
  logic out_valid_r;

  always_comb begin
    q = '0;
    for (int e = 0; e < N_ELEM; e++) begin
      q = st[Q_W].quo[e];
      if (st[Q_W].sing) begin
        res[N_ELEM-1-e] = '0;
      end else if (!st[Q_W].neg[e]) begin
        res[N_ELEM-1-e] = (q > SAT_POS_Q) ? SAT_POS : q[ELEM_W-1:0];
      end else begin
        res[N_ELEM-1-e] = (q > SAT_NEG_Q) ? SAT_NEG : (~q[ELEM_W-1:0] + 1'b1);
      end
    end
    out_nxt = {res, st[Q_W].sing};
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= st[Q_W].vld;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule

FILE: design/matrix_inverse_3x3_core.sv
// Top level of the 3x3 matrix inverse core: cofactor, determinant and divider
// pipelines. Depends on mi3_pkg, mi3_cofactor, mi3_det and mi3_divider.
//
// Usage: drive a matrix on in_data and raise start for one cycle per beat.
// A beat is taken at every rising edge with start high and busy low; busy
// stays low, so one matrix can enter in every cycle.
// Each result beat appears on out_data for exactly one cycle with out_valid
// high, in input order, after passing two cofactor stages, three
// determinant stages, one divider stage per quotient bit (34) and one
// output stage.
// Throughput is one matrix per cycle; no state links successive matrices.
// A zero determinant gives singular high and all nine elements zero.
// Synchronous active-low reset clears every valid bit; beats in flight are
// dropped. The receiver cannot stall the output.
`timescale 1ns / 1ps
module matrix_inverse_3x3_core
  import mi3_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  mi3_in_t  in_data,
  output logic     out_valid,
  output mi3_out_t out_data
);

  mi3_cof_t cof;
  mi3_div_t div;

  assign busy = 1'b0;

  mi3_cofactor u_cofactor (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy),
    .in_data (in_data),
    .cof_o   (cof)
  );

  mi3_det u_det (
    .clk   (clk),
    .rst_n (rst_n),
    .cof_i (cof),
    .div_o (div)
  );

  mi3_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .div_i     (div),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted beat did not produce a result on time");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(start, LATENCY))
    else $error("result without a matching input beat");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.singular) |-> (out_data[N_ELEM*ELEM_W:1] == '0))
    else $error("singular result with nonzero elements");

endmodule

FILE: sim/matrix_inverse_3x3_core_tb.sv
// Testbench for matrix_inverse_3x3_core: directed and random 3x3 matrices,
// checked against a self-contained adjugate predictor. Depends on mi3_pkg.
`timescale 1ns / 1ps
module matrix_inverse_3x3_core_tb;
  import mi3_pkg::*;

  class inverse_scoreboard;
    mi3_out_t pending[$];
    int errors;
    int checked;
    int singular_seen;

    function automatic logic [ELEM_W-1:0] scale_cofactor(logic signed [63:0] cf,
                                                         logic det_neg,
                                                         logic [127:0] dmag);
      logic [127:0] num;
      logic [127:0] quo;
      logic [63:0] cmag;
      logic neg;
      cmag = cf[63] ? -cf : cf;
      neg = cf[63] ^ det_neg;
      num = ({64'b0, cmag} << NUM_SHIFT) + dmag;
      quo = num / (dmag << 1);
      if (!neg) return (quo > 128'h7FFF_FFFF) ? SAT_POS : quo[31:0];
      if (quo > 128'h8000_0000) return SAT_NEG;
      return -quo[31:0];
    endfunction

    function automatic mi3_out_t invert(mi3_in_t m);
      logic [8:0][31:0] flat;
      logic [8:0][31:0] res;
      logic signed [63:0] e[9];
      logic signed [63:0] adj[9];
      logic signed [127:0] det;
      logic signed [127:0] x;
      logic signed [127:0] y;
      logic [127:0] dmag;
      flat = m;
      for (int k = 0; k < 9; k++) e[k] = $signed(flat[8-k]);
      adj[0] = e[4]*e[8] - e[5]*e[7];
      adj[1] = e[2]*e[7] - e[1]*e[8];
      adj[2] = e[1]*e[5] - e[2]*e[4];
      adj[3] = e[5]*e[6] - e[3]*e[8];
      adj[4] = e[0]*e[8] - e[2]*e[6];
      adj[5] = e[2]*e[3] - e[0]*e[5];
      adj[6] = e[3]*e[7] - e[4]*e[6];
      adj[7] = e[1]*e[6] - e[0]*e[7];
      adj[8] = e[0]*e[4] - e[1]*e[3];
      det = 0;
      for (int c = 0; c < 3; c++) begin
        x = e[c];
        y = adj[c*3];
        det = det + x * y;
      end
      if (det == 0) return {288'b0, 1'b1};
      dmag = det[127] ? -det : det;
      for (int k = 0; k < 9; k++) res[8-k] = scale_cofactor(adj[k], det[127], dmag);
      return {res, 1'b0};
    endfunction

    function void note_input(mi3_in_t m);
      pending.push_back(invert(m));
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH result %0d %s: got %h expected %h", checked, what, got, want);
      errors++;
    endtask

    task check_result(mi3_out_t got);
      mi3_out_t want;
      logic [8:0][31:0] g;
      logic [8:0][31:0] w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected beat", got[32:1], 32'd0);
        return;
      end
      want = pending.pop_front();
      g = got[288:1];
      w = want[288:1];
      for (int k = 0; k < 9; k++)
        if (g[8-k] !== w[8-k])
          report_mismatch($sformatf("r%0dc%0d", k / 3, k % 3), g[8-k], w[8-k]);
      if (got.singular !== want.singular)
        report_mismatch("singular", got.singular, want.singular);
      if (want.singular) singular_seen++;
      checked++;
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  mi3_in_t in_data;
  logic out_valid;
  mi3_out_t out_data;

  inverse_scoreboard board;
  int cycles = 0;
  int sent;

  matrix_inverse_3x3_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) board.check_result(out_data);
    if (cycles > 200000) begin
      $display("Timed out with %0d results outstanding", board.pending.size());
      $display("matrix_inverse_3x3_core test failed");
      $finish;
    end
  end

  task send_matrix(mi3_in_t m);
    start <= 1'b1;
    in_data <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_input(m);
    sent++;
  endtask

  task pause_sender(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [31:0] small_elem();
    return $urandom_range(0, 8 << FRAC_BITS) - (4 << FRAC_BITS);
  endfunction

  function automatic mi3_in_t make_matrix(int kind);
    logic [8:0][31:0] f;
    int a;
    int b;
    for (int k = 0; k < 9; k++)
      case (kind)
        0: f[k] = $urandom();
        1: f[k] = $signed(16'($urandom()));
        default: f[k] = small_elem();
      endcase
    if (kind >= 4) begin
      a = $urandom_range(0, 2);
      b = (a + $urandom_range(1, 2)) % 3;
      for (int c = 0; c < 3; c++) f[8 - (b*3 + c)] = f[8 - (a*3 + c)];
    end
    return f;
  endfunction

  function automatic mi3_in_t diag(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    return {a, 32'd0, 32'd0, 32'd0, b, 32'd0, 32'd0, 32'd0, c};
  endfunction

  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;
  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV = 32'h8000_0000;

  initial begin
    mi3_in_t directed[$];
    int burst;
    board = new();
    sent = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(diag(ONE, ONE, ONE));
    directed.push_back('0);
    directed.push_back({9{MAXV}});
    directed.push_back({9{MINV}});
    directed.push_back({9{32'hFFFF_FFFF}});
    directed.push_back(diag(MAXV, MAXV, MAXV));
    directed.push_back(diag(MINV, MINV, MINV));
    directed.push_back(diag(MINV, MAXV, MINV));
    directed.push_back(diag(32'd1, 32'd1, 32'd1));
    directed.push_back(diag(32'hFFFF_FFFF, 32'd1, 32'd1));
    directed.push_back(diag(32'd2, ONE, ONE));
    directed.push_back(diag(32'd3, ONE, ONE));
    directed.push_back(diag(-32'sd3, ONE, ONE));
    directed.push_back(diag(-ONE, ONE, 2 * ONE));
    directed.push_back({ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 9*ONE});
    directed.push_back({ONE, 2*ONE, 3*ONE, 32'd0, ONE, 4*ONE, 5*ONE, 6*ONE, 32'd0});
    directed.push_back({32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE, ONE, 32'd0, 32'd0});
    directed.push_back({MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, 32'd1});
    directed.push_back({MINV, MAXV, 32'd0, MAXV, MINV, 32'd0, 32'd0, 32'd0, MINV});
    directed.push_back({32'h5555_5555, 32'hAAAA_AAAA, 32'd7, 32'd9, 32'h1234_5678,
                        32'hFEDC_BA98, 32'd1, 32'd0, 32'h0F0F_0F0F});
    foreach (directed[i]) send_matrix(directed[i]);
    pause_sender(3);

    while (sent < 620) begin
      burst = $urandom_range(1, 40);
      repeat (burst) send_matrix(make_matrix($urandom_range(0, 5)));
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d matrices, checked %0d inverses, %0d of them singular.",
             sent, board.checked, board.singular_seen);
    if (board.errors == 0) $display("matrix_inverse_3x3_core test passed");
    else $display("matrix_inverse_3x3_core test failed");
    $finish;
  end
endmodule

FILE: matrix_inverse_3x3_core.f
design/mi3_pkg.sv
design/mi3_cofactor.sv
design/mi3_det.sv
design/mi3_divider.sv
design/matrix_inverse_3x3_core.sv
sim/matrix_inverse_3x3_core_tb.sv
